[hdl/gnds_pkg.sv]
// ============================================================================
// gnds_pkg: shared types and constants for the grid neighbor difference block
// ----------------------------------------------------------------------------
// Holds the fixed field widths, the configuration register indexes, the
// queue sizing and the flag bundle that travels from the front to the back.
// ============================================================================
`default_nettype none

package gnds_pkg;

    // Fixed widths of the configuration and result fields.
    localparam int THR_W       = 32;
    localparam int SIZE_CFG_W  = 11;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int IN_W        = 32;
    localparam int COUNT_W     = 22;
    localparam int EXCESS_W    = 53;
    localparam int DIFF_OUT_W  = 32;
    localparam int POS_OUT_W   = 10;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 2'd2;

    // Depth of the queue between front and back, and the width of its fill count.
    localparam int QUEUE_DEPTH = 4;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Classification of one sample, produced by the front.
    typedef struct packed {
        logic has_h;   // a left neighbor exists in this row
        logic has_v;   // an upper neighbor exists in the previous row
        logic last;    // this sample closes the grid
    } t_flags;

endpackage

`default_nettype wire

[hdl/gnds_ram.sv]
// ============================================================================
// gnds_ram: generic single-port RAM with registered read
// ----------------------------------------------------------------------------
// One address per cycle; a read and a write to the same address in the same
// cycle return the old contents.
// ============================================================================
`default_nettype none

module gnds_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Read-first storage with a registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

`default_nettype wire

[hdl/gnds_queue.sv]
// ============================================================================
// gnds_queue: small register queue between front and back
// ----------------------------------------------------------------------------
// First-in first-out store of classified samples with a fill count. The
// writer keeps track of space through the count.
// ============================================================================
`default_nettype none

module gnds_queue #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_push,
    input  wire logic [WIDTH-1:0]               i_data,
    input  wire logic                           i_pop,
    output logic      [WIDTH-1:0]               o_data,
    output logic                                o_not_empty,
    output logic      [$clog2(DEPTH+1)-1:0]     o_count
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_store [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    // Pointer wrap and count update.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_store[r_wr_ptr] <= i_data;
        end
    end

    assign o_data      = r_store[r_rd_ptr];
    assign o_not_empty = (r_count != '0);
    assign o_count     = r_count;

endmodule

`default_nettype wire

[hdl/gnds_front.sv]
// ============================================================================
// gnds_front: raster tracking and line store access
// ----------------------------------------------------------------------------
// Accepts samples, tracks row and column, reads the sample above from the
// line store while writing the new one, and pushes each classified sample
// into the queue in the cycle after it is accepted.
// ============================================================================
`default_nettype none

module gnds_front
    import gnds_pkg::*;
#(
    parameter int MAX_COLS = 1024,
    parameter int MAX_ROWS = 1024,
    parameter int SAMPLE_W = 32
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // Sample channel
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [IN_W-1:0]               i_sample,
    // Grid size registers
    input  wire logic [SIZE_CFG_W-1:0]         i_row_count,
    input  wire logic [SIZE_CFG_W-1:0]         i_column_count,
    // Line store
    output logic                               o_ram_we,
    output logic      [$clog2(MAX_COLS)-1:0]   o_ram_addr,
    output logic      [SAMPLE_W-1:0]           o_ram_wdata,
    input  wire logic [SAMPLE_W-1:0]           i_ram_rdata,
    // Queue
    input  wire logic [QCNT_W-1:0]             i_q_count,
    output logic                               o_push,
    output logic      [SAMPLE_W-1:0]           o_sample,
    output logic      [SAMPLE_W-1:0]           o_left,
    output logic      [SAMPLE_W-1:0]           o_above,
    output logic      [$clog2(MAX_ROWS)-1:0]   o_row,
    output logic      [$clog2(MAX_COLS)-1:0]   o_col,
    output t_flags                             o_flags
);

    localparam int CW     = $clog2(MAX_COLS);
    localparam int RW     = $clog2(MAX_ROWS);
    localparam int CSZ_W  = (CW + 1 > SIZE_CFG_W) ? CW + 1 : SIZE_CFG_W;
    localparam int RSZ_W  = (RW + 1 > SIZE_CFG_W) ? RW + 1 : SIZE_CFG_W;

    logic [CW-1:0]       r_col, n_col;
    logic [RW-1:0]       r_row, n_row;
    logic [SAMPLE_W-1:0] r_left;
    logic                r_s1_valid;
    logic [SAMPLE_W-1:0] r_s1_sample;
    logic [SAMPLE_W-1:0] r_s1_left;
    logic [RW-1:0]       r_s1_row;
    logic [CW-1:0]       r_s1_col;
    t_flags              r_s1_flags;

    logic                accept;
    logic [SAMPLE_W-1:0] sample;
    logic [CSZ_W-1:0]    cols_eff;
    logic [RSZ_W-1:0]    rows_eff;
    logic                row_end;
    logic                grid_end;
    logic [QCNT_W:0]     occupancy;

    // Space check: the queue plus the sample waiting on the line store read.
    assign occupancy = {1'b0, i_q_count} + (QCNT_W + 1)'(r_s1_valid);
    assign o_ready   = (occupancy < (QCNT_W + 1)'(QUEUE_DEPTH));
    assign accept    = i_valid && o_ready;
    assign sample    = i_sample[SAMPLE_W-1:0];

    // Grid size registers, with zero taken as one and oversize clipped.
    always_comb begin
        cols_eff = CSZ_W'(i_column_count);
        if (cols_eff == '0) begin
            cols_eff = CSZ_W'(1);
        end else if (cols_eff > CSZ_W'(MAX_COLS)) begin
            cols_eff = CSZ_W'(MAX_COLS);
        end
        rows_eff = RSZ_W'(i_row_count);
        if (rows_eff == '0) begin
            rows_eff = RSZ_W'(1);
        end else if (rows_eff > RSZ_W'(MAX_ROWS)) begin
            rows_eff = RSZ_W'(MAX_ROWS);
        end
    end

    // Row and grid end detection and raster position update.
    always_comb begin
        row_end  = ((CSZ_W'(r_col) + CSZ_W'(1)) >= cols_eff);
        grid_end = row_end && ((RSZ_W'(r_row) + RSZ_W'(1)) >= rows_eff);
        n_col    = r_col;
        n_row    = r_row;
        if (accept) begin
            if (grid_end) begin
                n_col = '0;
                n_row = '0;
            end else if (row_end) begin
                n_col = '0;
                n_row = r_row + RW'(1);
            end else begin
                n_col = r_col + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_col      <= n_col;
            r_row      <= n_row;
            r_s1_valid <= accept;
        end
    end

    // Sample data waiting for the line store read.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_left            <= sample;
            r_s1_sample       <= sample;
            r_s1_left         <= r_left;
            r_s1_row          <= r_row;
            r_s1_col          <= r_col;
            r_s1_flags.has_h  <= (r_col != '0);
            r_s1_flags.has_v  <= (r_row != '0);
            r_s1_flags.last   <= grid_end;
        end
    end

    // Line store: read the sample above and replace it in the same cycle.
    assign o_ram_we    = accept;
    assign o_ram_addr  = r_col;
    assign o_ram_wdata = sample;

    // Queue push in the cycle after the transfer, when the read data is ready.
    assign o_push   = r_s1_valid;
    assign o_sample = r_s1_sample;
    assign o_left   = r_s1_left;
    assign o_above  = i_ram_rdata;
    assign o_row    = r_s1_row;
    assign o_col    = r_s1_col;
    assign o_flags  = r_s1_flags;

endmodule

`default_nettype wire

[hdl/gnds_back.sv]
// ============================================================================
// gnds_back: difference arithmetic and statistics
// ----------------------------------------------------------------------------
// Five stages: absolute differences, threshold compare, excess pairing,
// statistics update with grid snapshot, and the result register.
// ============================================================================
`default_nettype none

module gnds_back
    import gnds_pkg::*;
#(
    parameter int SAMPLE_W = 32,
    parameter int ROW_W    = 10,
    parameter int COL_W    = 10
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic [THR_W-1:0]       i_threshold,
    // Queue
    input  wire logic                   i_q_not_empty,
    output logic                        o_q_pop,
    input  wire logic [SAMPLE_W-1:0]    i_q_sample,
    input  wire logic [SAMPLE_W-1:0]    i_q_left,
    input  wire logic [SAMPLE_W-1:0]    i_q_above,
    input  wire logic [ROW_W-1:0]       i_q_row,
    input  wire logic [COL_W-1:0]       i_q_col,
    input  t_flags                      i_q_flags,
    // Result channel
    output logic                        o_valid,
    input  wire logic                   i_ready,
    output logic [COUNT_W-1:0]          o_violation_count,
    output logic [EXCESS_W-1:0]         o_excess_sum,
    output logic [DIFF_OUT_W-1:0]       o_max_difference,
    output logic                        o_max_is_horizontal,
    output logic [POS_OUT_W-1:0]        o_max_row,
    output logic [POS_OUT_W-1:0]        o_max_column,
    output logic                        o_max_found
);

    localparam int SW = SAMPLE_W;

    logic advance;

    // Stage A registers
    logic              r_a_valid;
    logic [SW-1:0]     r_a_dh, r_a_dv;
    t_flags            r_a_flags;
    logic [ROW_W-1:0]  r_a_row;
    logic [COL_W-1:0]  r_a_col;
    // Stage B registers
    logic              r_b_valid;
    logic              r_b_vh, r_b_vv;
    logic [THR_W-1:0]  r_b_exh, r_b_exv;
    logic [SW-1:0]     r_b_dh, r_b_dv;
    t_flags            r_b_flags;
    logic [ROW_W-1:0]  r_b_row;
    logic [COL_W-1:0]  r_b_col;
    // Stage C registers
    logic              r_c_valid;
    logic [1:0]        r_c_nviol;
    logic [THR_W:0]    r_c_exsum;
    logic [SW-1:0]     r_c_dh, r_c_dv;
    t_flags            r_c_flags;
    logic [ROW_W-1:0]  r_c_row;
    logic [COL_W-1:0]  r_c_col;
    // Running statistics
    logic [COUNT_W-1:0]  r_cnt, n_cnt;
    logic [EXCESS_W-1:0] r_tot, n_tot;
    logic [SW-1:0]       r_bh, n_bh;
    logic [ROW_W-1:0]    r_bh_row, n_bh_row;
    logic [COL_W-1:0]    r_bh_col, n_bh_col;
    logic [SW-1:0]       r_bv, n_bv;
    logic [ROW_W-1:0]    r_bv_row, n_bv_row;
    logic [COL_W-1:0]    r_bv_col, n_bv_col;
    // Grid snapshot
    logic                r_fin_valid;
    logic [COUNT_W-1:0]  r_fin_cnt;
    logic [EXCESS_W-1:0] r_fin_tot;
    logic [SW-1:0]       r_fin_bh, r_fin_bv;
    logic [ROW_W-1:0]    r_fin_bh_row, r_fin_bv_row;
    logic [COL_W-1:0]    r_fin_bh_col, r_fin_bv_col;
    // Result register
    logic                r_out_valid;

    logic [SW:0]         sub_h_ab, sub_h_ba, sub_v_ab, sub_v_ba;
    logic [SW-1:0]       dh, dv;
    logic [THR_W:0]      sub_h_thr, sub_v_thr;
    logic                vh, vv;
    logic [COUNT_W:0]    cnt_sum;
    logic [EXCESS_W:0]   tot_sum;
    logic                sel_h;
    logic [SW-1:0]       sel_md;
    logic [ROW_W-1:0]    sel_row;
    logic [COL_W-1:0]    sel_col;

    // The whole back moves on unless a result waits untaken.
    assign advance = !r_out_valid || i_ready;
    assign o_q_pop = advance && i_q_not_empty;

    // Stage A: absolute differences, sign-extended by one bit.
    always_comb begin
        sub_h_ab = {i_q_left[SW-1], i_q_left} - {i_q_sample[SW-1], i_q_sample};
        sub_h_ba = {i_q_sample[SW-1], i_q_sample} - {i_q_left[SW-1], i_q_left};
        sub_v_ab = {i_q_above[SW-1], i_q_above} - {i_q_sample[SW-1], i_q_sample};
        sub_v_ba = {i_q_sample[SW-1], i_q_sample} - {i_q_above[SW-1], i_q_above};
        dh = sub_h_ab[SW] ? sub_h_ba[SW-1:0] : sub_h_ab[SW-1:0];
        dv = sub_v_ab[SW] ? sub_v_ba[SW-1:0] : sub_v_ab[SW-1:0];
    end

    // Stage B: threshold compare through the borrow of the excess.
    always_comb begin
        sub_h_thr = {1'b0, THR_W'(r_a_dh)} - {1'b0, i_threshold};
        sub_v_thr = {1'b0, THR_W'(r_a_dv)} - {1'b0, i_threshold};
        vh = r_a_flags.has_h && !sub_h_thr[THR_W] && (sub_h_thr[THR_W-1:0] != '0);
        vv = r_a_flags.has_v && !sub_v_thr[THR_W] && (sub_v_thr[THR_W-1:0] != '0);
    end

    // Stage D: saturating accumulation and best-edge tracking.
    always_comb begin
        cnt_sum = {1'b0, r_cnt} + (COUNT_W + 1)'(r_c_nviol);
        n_cnt   = cnt_sum[COUNT_W] ? '1 : cnt_sum[COUNT_W-1:0];
        tot_sum = {1'b0, r_tot} + (EXCESS_W + 1)'(r_c_exsum);
        n_tot   = tot_sum[EXCESS_W] ? '1 : tot_sum[EXCESS_W-1:0];

        n_bh     = r_bh;
        n_bh_row = r_bh_row;
        n_bh_col = r_bh_col;
        if (r_c_flags.has_h && (r_c_dh > r_bh)) begin
            n_bh     = r_c_dh;
            n_bh_row = r_c_row;
            n_bh_col = r_c_col - COL_W'(1);
        end
        n_bv     = r_bv;
        n_bv_row = r_bv_row;
        n_bv_col = r_bv_col;
        if (r_c_flags.has_v && (r_c_dv > r_bv)) begin
            n_bv     = r_c_dv;
            n_bv_row = r_c_row - ROW_W'(1);
            n_bv_col = r_c_col;
        end
    end

    // Stage E: pick the winning orientation; horizontal wins a tie.
    always_comb begin
        sel_h   = (r_fin_bh >= r_fin_bv);
        sel_md  = sel_h ? r_fin_bh : r_fin_bv;
        sel_row = sel_h ? r_fin_bh_row : r_fin_bv_row;
        sel_col = sel_h ? r_fin_bh_col : r_fin_bv_col;
    end

    // Stage valid bits and running statistics.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_b_valid   <= 1'b0;
            r_c_valid   <= 1'b0;
            r_fin_valid <= 1'b0;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
            r_tot       <= '0;
            r_bh        <= '0;
            r_bh_row    <= '0;
            r_bh_col    <= '0;
            r_bv        <= '0;
            r_bv_row    <= '0;
            r_bv_col    <= '0;
        end else if (advance) begin
            r_a_valid   <= o_q_pop;
            r_b_valid   <= r_a_valid;
            r_c_valid   <= r_b_valid;
            r_fin_valid <= r_c_valid && r_c_flags.last;
            r_out_valid <= r_fin_valid;
            if (r_c_valid) begin
                if (r_c_flags.last) begin
                    r_cnt    <= '0;
                    r_tot    <= '0;
                    r_bh     <= '0;
                    r_bh_row <= '0;
                    r_bh_col <= '0;
                    r_bv     <= '0;
                    r_bv_row <= '0;
                    r_bv_col <= '0;
                end else begin
                    r_cnt    <= n_cnt;
                    r_tot    <= n_tot;
                    r_bh     <= n_bh;
                    r_bh_row <= n_bh_row;
                    r_bh_col <= n_bh_col;
                    r_bv     <= n_bv;
                    r_bv_row <= n_bv_row;
                    r_bv_col <= n_bv_col;
                end
            end
        end
    end

    // Stage payloads, grid snapshot and result fields.
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_a_dh    <= dh;
            r_a_dv    <= dv;
            r_a_flags <= i_q_flags;
            r_a_row   <= i_q_row;
            r_a_col   <= i_q_col;

            r_b_vh    <= vh;
            r_b_vv    <= vv;
            r_b_exh   <= sub_h_thr[THR_W-1:0];
            r_b_exv   <= sub_v_thr[THR_W-1:0];
            r_b_dh    <= r_a_dh;
            r_b_dv    <= r_a_dv;
            r_b_flags <= r_a_flags;
            r_b_row   <= r_a_row;
            r_b_col   <= r_a_col;

            r_c_nviol <= 2'(r_b_vh) + 2'(r_b_vv);
            r_c_exsum <= (r_b_vh ? {1'b0, r_b_exh} : '0) + (r_b_vv ? {1'b0, r_b_exv} : '0);
            r_c_dh    <= r_b_dh;
            r_c_dv    <= r_b_dv;
            r_c_flags <= r_b_flags;
            r_c_row   <= r_b_row;
            r_c_col   <= r_b_col;

            r_fin_cnt    <= n_cnt;
            r_fin_tot    <= n_tot;
            r_fin_bh     <= n_bh;
            r_fin_bh_row <= n_bh_row;
            r_fin_bh_col <= n_bh_col;
            r_fin_bv     <= n_bv;
            r_fin_bv_row <= n_bv_row;
            r_fin_bv_col <= n_bv_col;

            if (r_fin_valid) begin
                o_violation_count <= r_fin_cnt;
                o_excess_sum      <= r_fin_tot;
                o_max_difference  <= DIFF_OUT_W'(sel_md);
                o_max_found       <= (sel_md != '0);
                if (sel_md != '0) begin
                    o_max_is_horizontal <= sel_h;
                    o_max_row           <= POS_OUT_W'(sel_row);
                    o_max_column        <= POS_OUT_W'(sel_col);
                end else begin
                    o_max_is_horizontal <= 1'b0;
                    o_max_row           <= '0;
                    o_max_column        <= '0;
                end
            end
        end
    end

    assign o_valid = r_out_valid;

endmodule

`default_nettype wire

[hdl/grid_neighbor_difference_stats.sv]
// ============================================================================
// grid_neighbor_difference_stats: neighbor difference statistics of a grid
// ----------------------------------------------------------------------------
// Takes grid samples in raster order and reports, after each grid's last
// sample, the count and saturating excess sum of neighbor differences above
// a threshold and the largest difference with its place and orientation.
//
//   Channel   Direction  Handshake              Contents
//   sample    in         i_valid / o_ready      i_sample, one grid value
//   result    out        o_valid / i_ready      statistics of one grid
//   config    in         i_cfg_we (no wait)     i_cfg_idx, i_cfg_data
//
// One sample is taken per cycle; the front's rate is set by the single-port
// line store, read and written at the sample's column in the same cycle.
// A result follows a grid's last sample through the front register, queue
// and back stages. A stalled result holds the back pipeline; the four-entry
// queue keeps the front taking samples until it fills.
// Reset needs no clearing pass: the line store is only read in rows below
// the first, after it has been written.
// ============================================================================
`default_nettype none

module grid_neighbor_difference_stats
    import gnds_pkg::*;
#(
    parameter int MAX_COLUMNS  = 1024,
    parameter int MAX_ROWS     = 1024,
    parameter int SAMPLE_WIDTH = 32
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // Configuration
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data,
    // Sample channel
    input  wire logic                   i_valid,
    output logic                        o_ready,
    input  wire logic [IN_W-1:0]        i_sample,
    // Result channel
    output logic                        o_valid,
    input  wire logic                   i_ready,
    output logic [COUNT_W-1:0]          o_violation_count,
    output logic [EXCESS_W-1:0]         o_excess_sum,
    output logic [DIFF_OUT_W-1:0]       o_max_difference,
    output logic                        o_max_is_horizontal,
    output logic [POS_OUT_W-1:0]        o_max_row,
    output logic [POS_OUT_W-1:0]        o_max_column,
    output logic                        o_max_found
);

    localparam int CW     = $clog2(MAX_COLUMNS);
    localparam int RW     = $clog2(MAX_ROWS);
    localparam int SW     = SAMPLE_WIDTH;
    localparam int ITEM_W = $bits(t_flags) + RW + CW + 3 * SW;

    logic [THR_W-1:0]      r_threshold;
    logic [SIZE_CFG_W-1:0] r_row_count;
    logic [SIZE_CFG_W-1:0] r_column_count;

    logic                  ram_we;
    logic [CW-1:0]         ram_addr;
    logic [SW-1:0]         ram_wdata;
    logic [SW-1:0]         ram_rdata;

    logic                  push;
    logic [SW-1:0]         f_sample, f_left, f_above;
    logic [RW-1:0]         f_row;
    logic [CW-1:0]         f_col;
    t_flags                f_flags;

    logic                  pop;
    logic                  q_not_empty;
    logic [QCNT_W-1:0]     q_count;
    logic [ITEM_W-1:0]     q_data;
    logic [SW-1:0]         q_sample, q_left, q_above;
    logic [RW-1:0]         q_row;
    logic [CW-1:0]         q_col;
    t_flags                q_flags;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold    <= '0;
            r_row_count    <= SIZE_CFG_W'(1);
            r_column_count <= SIZE_CFG_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_THRESHOLD:    r_threshold    <= i_cfg_data[THR_W-1:0];
                REG_ROW_COUNT:    r_row_count    <= i_cfg_data[SIZE_CFG_W-1:0];
                REG_COLUMN_COUNT: r_column_count <= i_cfg_data[SIZE_CFG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Front: raster position and line store access.
    gnds_front #(
        .MAX_COLS (MAX_COLUMNS),
        .MAX_ROWS (MAX_ROWS),
        .SAMPLE_W (SW)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_sample       (i_sample),
        .i_row_count    (r_row_count),
        .i_column_count (r_column_count),
        .o_ram_we       (ram_we),
        .o_ram_addr     (ram_addr),
        .o_ram_wdata    (ram_wdata),
        .i_ram_rdata    (ram_rdata),
        .i_q_count      (q_count),
        .o_push         (push),
        .o_sample       (f_sample),
        .o_left         (f_left),
        .o_above        (f_above),
        .o_row          (f_row),
        .o_col          (f_col),
        .o_flags        (f_flags)
    );

    // Line store holding the previous row.
    gnds_ram #(
        .WIDTH (SW),
        .DEPTH (MAX_COLUMNS)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    // Queue between front and back.
    gnds_queue #(
        .WIDTH (ITEM_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_data      ({f_flags, f_row, f_col, f_left, f_above, f_sample}),
        .i_pop       (pop),
        .o_data      (q_data),
        .o_not_empty (q_not_empty),
        .o_count     (q_count)
    );

    assign {q_flags, q_row, q_col, q_left, q_above, q_sample} = q_data;

    // Back: arithmetic, statistics and result register.
    gnds_back #(
        .SAMPLE_W (SW),
        .ROW_W    (RW),
        .COL_W    (CW)
    ) u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_threshold         (r_threshold),
        .i_q_not_empty       (q_not_empty),
        .o_q_pop             (pop),
        .i_q_sample          (q_sample),
        .i_q_left            (q_left),
        .i_q_above           (q_above),
        .i_q_row             (q_row),
        .i_q_col             (q_col),
        .i_q_flags           (q_flags),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_violation_count   (o_violation_count),
        .o_excess_sum        (o_excess_sum),
        .o_max_difference    (o_max_difference),
        .o_max_is_horizontal (o_max_is_horizontal),
        .o_max_row           (o_max_row),
        .o_max_column        (o_max_column),
        .o_max_found         (o_max_found)
    );

endmodule

`default_nettype wire
